[hw/rtl/igew_pkg.sv]
// igew_pkg: shared types and fixed constants of the pixel-grid edge weight block.
// Standalone; used by igew_front, igew_emitter and the top level.
package igew_pkg;

    localparam int IDX_BITS  = 24;   // linear pixel index width
    localparam int SIZE_BITS = 13;   // width of the size registers
    localparam int CFG_BITS  = 2;    // register index width

    // Register indexes on the configuration port
    localparam logic [CFG_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_BITS-1:0] CFG_WEIGHT_MODE  = 2'd2;

    // Record kinds
    localparam logic REC_VERTEX = 1'b0;
    localparam logic REC_EDGE   = 1'b1;

    // Weight modes
    localparam logic MODE_ABS_DIFF = 1'b0;
    localparam logic MODE_AVERAGE  = 1'b1;

    localparam logic [SIZE_BITS-1:0] SIZE_RESET = 13'd4096;

    // Control part of one pixel held between front end and emitter
    typedef struct packed {
        logic                has_left;
        logic                has_up;
        logic [IDX_BITS-1:0] here;
        logic [IDX_BITS-1:0] left_index;
        logic [IDX_BITS-1:0] up_index;
    } item_t;

endpackage

[hw/rtl/igew_line_buffer.sv]
// igew_line_buffer: one row of pixels, one write and one registered read per cycle.
// No dependencies.
module igew_line_buffer #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 16
) (
    input  logic          clk,
    input  logic          access,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    // read returns the old entry when the same address is written
    always_ff @(posedge clk)
    begin
        if (access)
        begin
            mem[addr] <= wdata;
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/igew_front.sv]
// igew_front: configuration registers, raster counters and the held pixel register.
// Depends on igew_pkg.
module igew_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int PIXEL_BITS = 16,
    parameter int CB         = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [igew_pkg::CFG_BITS-1:0]      cfg_index,
    input  logic [igew_pkg::SIZE_BITS-1:0]     cfg_data,
    input  logic                               accept,
    input  logic                               release_item,
    input  logic [PIXEL_BITS-1:0]              pixel_value,
    output logic [CB-1:0]                      column,
    output logic                               item_valid,
    output igew_pkg::item_t                    item,
    output logic [PIXEL_BITS-1:0]              item_pixel,
    output logic [PIXEL_BITS-1:0]              item_left,
    output logic                               weight_mode
);

    localparam int EW  = $clog2(MAX_WIDTH + 1);
    localparam int EH  = $clog2(MAX_HEIGHT + 1);
    localparam int RB  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int IB  = igew_pkg::IDX_BITS;

    logic [igew_pkg::SIZE_BITS-1:0] width_reg;
    logic [igew_pkg::SIZE_BITS-1:0] height_reg;
    logic                           mode_reg;
    logic [CB-1:0]                  col_reg;
    logic [CB-1:0]                  col_next;
    logic [RB-1:0]                  row_reg;
    logic [RB-1:0]                  row_next;
    logic [IB-1:0]                  count_reg;
    logic [IB-1:0]                  count_next;
    logic [PIXEL_BITS-1:0]          left_pixel_reg;
    logic                           item_valid_reg;
    igew_pkg::item_t                item_reg;
    igew_pkg::item_t                item_next;
    logic [PIXEL_BITS-1:0]          pix_reg;
    logic [PIXEL_BITS-1:0]          left_reg;
    logic [EW-1:0]                  width_eff;
    logic [EH-1:0]                  height_eff;
    logic [CB:0]                    col_inc;
    logic [RB:0]                    row_inc;

    // clamp sizes to the range one .. maximum
    always_comb
    begin
        if (width_reg == '0)
            width_eff = EW'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            width_eff = EW'(MAX_WIDTH);
        else
            width_eff = EW'(width_reg);

        if (height_reg == '0)
            height_eff = EH'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            height_eff = EH'(MAX_HEIGHT);
        else
            height_eff = EH'(height_reg);
    end

    // advance the raster counters, wrap at row and frame end
    always_comb
    begin
        col_inc    = {1'b0, col_reg} + 1'b1;
        row_inc    = {1'b0, row_reg} + 1'b1;
        col_next   = col_inc[CB-1:0];
        row_next   = row_reg;
        count_next = count_reg + 1'b1;
        if (32'(col_inc) >= 32'(width_eff))
        begin
            col_next = '0;
            row_next = row_inc[RB-1:0];
            if (32'(row_inc) >= 32'(height_eff))
            begin
                row_next   = '0;
                count_next = '0;
            end
        end
    end

    always_comb
    begin
        item_next.has_left   = (col_reg != '0);
        item_next.has_up     = (row_reg != '0);
        item_next.here       = count_reg;
        item_next.left_index = count_reg - 1'b1;
        item_next.up_index   = count_reg - IB'(width_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= igew_pkg::SIZE_RESET;
            height_reg     <= igew_pkg::SIZE_RESET;
            mode_reg       <= igew_pkg::MODE_ABS_DIFF;
            col_reg        <= '0;
            row_reg        <= '0;
            count_reg      <= '0;
            left_pixel_reg <= '0;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    igew_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    igew_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    igew_pkg::CFG_WEIGHT_MODE:  mode_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
            if (accept)
            begin
                col_reg        <= col_next;
                row_reg        <= row_next;
                count_reg      <= count_next;
                left_pixel_reg <= pixel_value;
                item_valid_reg <= 1'b1;
            end
            else if (release_item)
            begin
                item_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
            pix_reg  <= pixel_value;
            left_reg <= left_pixel_reg;
        end
    end

    assign column      = col_reg;
    assign item_valid  = item_valid_reg;
    assign item        = item_reg;
    assign item_pixel  = pix_reg;
    assign item_left   = left_reg;
    assign weight_mode = mode_reg;

`ifndef SYNTH
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < 32'(MAX_WIDTH))
        else $error("column counter beyond line buffer depth");

    a_accept_free: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!item_valid_reg || release_item))
        else $error("pixel taken while held item not released");

    a_left_index: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (item_reg.left_index == item_reg.here - 1'b1))
        else $error("left index not one below current index");
`endif

endmodule

[hw/rtl/igew_emitter.sv]
// igew_emitter: turns one held pixel into vertex and edge records, one per cycle unless the record port stalls.
// Depends on igew_pkg.
module igew_emitter #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    input  igew_pkg::item_t                    item,
    input  logic [PIXEL_BITS-1:0]              item_pixel,
    input  logic [PIXEL_BITS-1:0]              item_left,
    input  logic [PIXEL_BITS-1:0]              item_up,
    input  logic                               weight_mode,
    input  logic                               out_ready,
    output logic                               release_item,
    output logic                               out_valid,
    output logic                               record_kind,
    output logic [igew_pkg::IDX_BITS-1:0]      first_index,
    output logic [igew_pkg::IDX_BITS-1:0]      second_index,
    output logic [PIXEL_BITS-1:0]              vertex_value,
    output logic [PIXEL_BITS:0]                weight_halves,
    output logic                               last
);

    localparam int IB = igew_pkg::IDX_BITS;

    logic                  vert_done_reg;
    logic                  left_done_reg;
    logic                  emit;
    logic                  is_vertex;
    logic                  is_left;
    logic                  rec_last;
    logic [PIXEL_BITS-1:0] other;
    logic [PIXEL_BITS-1:0] diff;
    logic [PIXEL_BITS:0]   weight;
    logic [IB-1:0]         rec_first;

    logic                  out_valid_reg;
    logic                  kind_reg;
    logic [IB-1:0]         first_reg;
    logic [IB-1:0]         second_reg;
    logic [PIXEL_BITS-1:0] value_reg;
    logic [PIXEL_BITS:0]   weight_reg;
    logic                  last_reg;

    assign emit      = item_valid && (!out_valid_reg || out_ready);
    assign is_vertex = !vert_done_reg;
    assign is_left   = vert_done_reg && item.has_left && !left_done_reg;

    always_comb
    begin
        if (is_vertex)
            rec_last = !item.has_left && !item.has_up;
        else if (is_left)
            rec_last = !item.has_up;
        else
            rec_last = 1'b1;
    end

    assign release_item = emit && rec_last;

    // edge weight in halves: twice the difference, or the sum
    assign other = is_left ? item_left : item_up;
    assign diff  = (item_pixel >= other) ? (item_pixel - other) : (other - item_pixel);
    always_comb
    begin
        if (weight_mode == igew_pkg::MODE_AVERAGE)
            weight = {1'b0, item_pixel} + {1'b0, other};
        else
            weight = {diff, 1'b0};
    end

    assign rec_first = is_left ? item.left_index : item.up_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vert_done_reg <= 1'b0;
            left_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (release_item)
            begin
                vert_done_reg <= 1'b0;
                left_done_reg <= 1'b0;
            end
            else if (emit)
            begin
                vert_done_reg <= 1'b1;
                if (is_left)
                    left_done_reg <= 1'b1;
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            last_reg <= rec_last;
            if (is_vertex)
            begin
                kind_reg   <= igew_pkg::REC_VERTEX;
                first_reg  <= item.here;
                second_reg <= '0;
                value_reg  <= item_pixel;
                weight_reg <= '0;
            end
            else
            begin
                kind_reg   <= igew_pkg::REC_EDGE;
                first_reg  <= rec_first;
                second_reg <= item.here;
                value_reg  <= '0;
                weight_reg <= weight;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign record_kind   = kind_reg;
    assign first_index   = first_reg;
    assign second_index  = second_reg;
    assign vertex_value  = value_reg;
    assign weight_halves = weight_reg;
    assign last          = last_reg;

`ifndef SYNTH
    a_release_restart: assert property (@(posedge clk) disable iff (!rst_n)
        release_item |=> (!vert_done_reg && !left_done_reg))
        else $error("progress flags not cleared after item release");

    a_left_after_vertex: assert property (@(posedge clk) disable iff (!rst_n)
        left_done_reg |-> vert_done_reg)
        else $error("left edge sent before vertex");

    a_edge_exists: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !is_vertex) |-> (item.has_left || item.has_up))
        else $error("edge record for a pixel with no neighbour");
`endif

endmodule

[hw/rtl/image_grid_edge_weights.sv]
// image_grid_edge_weights: top level of the 4-connected pixel-grid graph builder.
// Depends on igew_pkg, igew_line_buffer, igew_front and igew_emitter.
//
//  channel   direction  handshake             payload
//  ------------------------------------------------------------------------------
//  pixel     in         in_valid / in_ready   pixel_value
//  record    out        out_valid / out_ready record_kind, first_index, second_index,
//                                             vertex_value, weight_halves, last
//  config    in         cfg_write             cfg_index, cfg_data
//
// Each pixel beat gives one vertex record, then a left edge and an upper edge
// where those neighbours exist, one record per cycle while the record port does
// not stall: one to three records per pixel, three in the body of the image.
// A pixel beat is taken into the held pixel register while the previous pixel's
// last record is loaded into the output register, so beats follow back to back.
// The line buffer is read and written at the column of the incoming pixel in the
// same cycle; the read data is registered alongside the held pixel.
// Reset brings counters, control flags and configuration registers to defaults;
// the line buffer needs no clearing pass, as reads made in the first row go unused.
// A stall on the record port holds the output register and the held pixel, and
// in_ready drops until the held pixel's last record goes out.
module image_grid_edge_weights #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int PIXEL_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [igew_pkg::CFG_BITS-1:0]      cfg_index,
    input  logic [igew_pkg::SIZE_BITS-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [PIXEL_BITS-1:0]              pixel_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               record_kind,
    output logic [igew_pkg::IDX_BITS-1:0]      first_index,
    output logic [igew_pkg::IDX_BITS-1:0]      second_index,
    output logic [PIXEL_BITS-1:0]              vertex_value,
    output logic [PIXEL_BITS:0]                weight_halves,
    output logic                               last
);

    // line buffer address width
    localparam int CB = $clog2(MAX_WIDTH);

    logic                  accept;
    logic                  release_item;
    logic                  item_valid;
    igew_pkg::item_t       item;
    logic [CB-1:0]         column;
    logic [PIXEL_BITS-1:0] item_pixel;
    logic [PIXEL_BITS-1:0] item_left;
    logic [PIXEL_BITS-1:0] item_up;
    logic                  weight_mode;

    // take a new beat when the held pixel is empty or leaves this cycle
    assign in_ready = !item_valid || release_item;
    assign accept   = in_valid && in_ready;

    igew_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS),
        .CB         (CB)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .release_item (release_item),
        .pixel_value  (pixel_value),
        .column       (column),
        .item_valid   (item_valid),
        .item         (item),
        .item_pixel   (item_pixel),
        .item_left    (item_left),
        .weight_mode  (weight_mode)
    );

    // upper neighbour: the value last written at this column
    igew_line_buffer #(
        .DEPTH (MAX_WIDTH),
        .AW    (CB),
        .DW    (PIXEL_BITS)
    ) u_line_buffer (
        .clk    (clk),
        .access (accept),
        .addr   (column),
        .wdata  (pixel_value),
        .rdata  (item_up)
    );

    igew_emitter #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_emitter (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item          (item),
        .item_pixel    (item_pixel),
        .item_left     (item_left),
        .item_up       (item_up),
        .weight_mode   (weight_mode),
        .out_ready     (out_ready),
        .release_item  (release_item),
        .out_valid     (out_valid),
        .record_kind   (record_kind),
        .first_index   (first_index),
        .second_index  (second_index),
        .vertex_value  (vertex_value),
        .weight_halves (weight_halves),
        .last          (last)
    );

endmodule
